// File: hw/rtl/alr_pkg.sv
package alr_pkg;

  localparam int TILE_SIZE_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [0:0] REG_CLIP_WIDTH  = 1'b0;
  localparam logic [0:0] REG_CLIP_HEIGHT = 1'b1;

  typedef struct packed {
    logic [4:0]  x_start;
    logic [4:0]  y_start;
    logic [4:0]  x_stop;
    logic [4:0]  y_stop;
    logic [23:0] line_color;
  } line_in_t;

  typedef struct packed {
    logic [5:0]  pixel_x;
    logic [5:0]  pixel_y;
    logic [31:0] pixel_color;
    logic        visible;
    logic        last;
  } pixel_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic final_pixel;
  } dp_sts_t;

endpackage

// File: hw/rtl/alr_ctrl.sv
module alr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output alr_pkg::dp_cmd_t  cmd,
  input  alr_pkg::dp_sts_t  sts
);
  import alr_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.final_pixel ? ST_IDLE : ST_EMIT;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  property p_no_input_while_output;
    @(posedge clk) disable iff (!rst_n) !(in_ready && out_valid);
  endproperty
  assert property (p_no_input_while_output) else $error("input taken while a pixel is pending");

  property p_div_then_emit;
    @(posedge clk) disable iff (!rst_n)
      (state_r == ST_DIV && sts.div_done) |=> out_valid;
  endproperty
  assert property (p_div_then_emit) else $error("no pixel after divide");

  property p_load_goes_div;
    @(posedge clk) disable iff (!rst_n) cmd.load |=> (state_r == ST_DIV);
  endproperty
  assert property (p_load_goes_div) else $error("load did not start divide");
endmodule

// File: hw/rtl/alr_datapath.sv
module alr_datapath #(
  parameter int FRAC_BITS = alr_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  alr_pkg::line_in_t   in_data,
  input  alr_pkg::dp_cmd_t    cmd,
  output alr_pkg::dp_sts_t    sts,
  input  logic [5:0]          clip_width,
  input  logic [5:0]          clip_height,
  output alr_pkg::pixel_out_t out_data
);
  import alr_pkg::*;

  localparam int CW = 6;
  localparam int NUMW = 5 + FRAC_BITS;
  localparam int DCW = $clog2(NUMW + 1);
  localparam int PW = FRAC_BITS + 8;
  localparam logic [PW-1:0] ONE_P = PW'(1) << FRAC_BITS;
  localparam int HALF_I = (FRAC_BITS > 8) ? (1 << (FRAC_BITS - 9)) : 0;
  localparam logic [FRAC_BITS:0] HALF = (FRAC_BITS + 1)'(HALF_I);

  logic [4:0]      x1_r, y1_r, x2_r, y2_r;
  logic [23:0]     color_r;
  logic            steep_r, neg_r;
  logic [4:0]      dx_r;
  logic [NUMW-1:0] quo_r;
  logic [4:0]      rem_r;
  logic [DCW-1:0]  dcnt_r;
  logic [PW-1:0]   slope_r, pos_r;
  logic [CW-1:0]   major_r;
  logic [2:0]      phase_r;

  logic [4:0] ax1, ay1, ax2, ay2;
  logic [4:0] adx, ady;
  logic       st, sw;
  logic [4:0] ox1, oy1, ox2, oy2;
  logic [5:0] rem_sh;
  logic       q_bit;
  logic [NUMW-1:0] num_bit;

  always_comb begin
    adx = (in_data.x_stop > in_data.x_start) ? in_data.x_stop - in_data.x_start
                                              : in_data.x_start - in_data.x_stop;
    ady = (in_data.y_stop > in_data.y_start) ? in_data.y_stop - in_data.y_start
                                              : in_data.y_start - in_data.y_stop;
    st  = ady > adx;
    ax1 = st ? in_data.y_start : in_data.x_start;
    ay1 = st ? in_data.x_start : in_data.y_start;
    ax2 = st ? in_data.y_stop  : in_data.x_stop;
    ay2 = st ? in_data.x_stop  : in_data.y_stop;
    sw  = ax1 > ax2;
    ox1 = sw ? ax2 : ax1;
    oy1 = sw ? ay2 : ay1;
    ox2 = sw ? ax1 : ax2;
    oy2 = sw ? ay1 : ay2;
  end

  // numerator |dy| << FRAC_BITS, fed msb first
  logic [4:0] ady_r;
  assign num_bit = NUMW'(ady_r) << FRAC_BITS;
  assign rem_sh  = {rem_r, num_bit[dcnt_r[DCW-1:0] - DCW'(1)]};
  assign q_bit   = rem_sh >= {1'b0, dx_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1_r    <= ox1;
      y1_r    <= oy1;
      x2_r    <= ox2;
      y2_r    <= oy2;
      color_r <= in_data.line_color;
      steep_r <= st;
      neg_r   <= oy2 < oy1;
      dx_r    <= ox2 - ox1;
      ady_r   <= (oy2 > oy1) ? oy2 - oy1 : oy1 - oy2;
      quo_r   <= '0;
      rem_r   <= '0;
      dcnt_r  <= DCW'(NUMW);
      phase_r <= '0;
    end else if (cmd.div_step) begin
      if (dcnt_r != '0) begin
        quo_r  <= {quo_r[NUMW-2:0], q_bit};
        rem_r  <= q_bit ? 5'(rem_sh - {1'b0, dx_r}) : rem_sh[4:0];
        dcnt_r <= dcnt_r - DCW'(1);
      end else begin
        if (dx_r == '0) begin
          slope_r <= ONE_P;
        end else begin
          slope_r <= neg_r ? PW'(-PW'(quo_r)) : PW'(quo_r);
        end
      end
      pos_r   <= PW'(y1_r) << FRAC_BITS;
      major_r <= CW'(x1_r) + CW'(1);
    end else if (cmd.emit) begin
      if (phase_r < 3'd4) begin
        phase_r <= phase_r + 3'd1;
        if (phase_r == 3'd3) begin
          pos_r <= pos_r + slope_r;
        end
      end else if (phase_r == 3'd4) begin
        phase_r <= 3'd5;
      end else begin
        phase_r <= 3'd4;
        pos_r   <= pos_r + slope_r;
        major_r <= major_r + CW'(1);
      end
    end
  end

  assign sts.div_done = (dcnt_r == '0);

  logic [CW-1:0]  maj, mnr, ip, px, py;
  logic [8:0]     up, cov;
  logic [FRAC_BITS:0] fr;
  logic           interior;

  always_comb begin
    interior = (CW'(x2_r) > CW'(x1_r) + CW'(1));
    fr  = {1'b0, pos_r[FRAC_BITS-1:0]} + HALF;
    up  = 9'(fr >> (FRAC_BITS - 8));
    ip  = CW'(pos_r >> FRAC_BITS);
    maj = '0;
    mnr = '0;
    cov = '0;
    unique case (phase_r)
      3'd0: begin maj = CW'(x1_r); mnr = CW'(y1_r);          cov = 9'd128; end
      3'd1: begin maj = CW'(x1_r); mnr = CW'(y1_r) + CW'(1); cov = 9'd0;   end
      3'd2: begin maj = CW'(x2_r); mnr = CW'(y2_r);          cov = 9'd128; end
      3'd3: begin maj = CW'(x2_r); mnr = CW'(y2_r) + CW'(1); cov = 9'd0;   end
      3'd4: begin maj = major_r;   mnr = ip;                 cov = 9'd256 - up; end
      3'd5: begin maj = major_r;   mnr = ip + CW'(1);        cov = up;     end
      default: begin maj = '0; mnr = '0; cov = '0; end
    endcase
    px = steep_r ? mnr : maj;
    py = steep_r ? maj : mnr;
  end

  function automatic logic [7:0] scl(input logic [7:0] c, input logic [8:0] k);
    logic [17:0] p;
    p = 18'(c) * 18'(k) + 18'd128;
    return p[15:8];
  endfunction

  always_comb begin
    sts.final_pixel = (phase_r == 3'd3 && !interior) ||
                      (phase_r == 3'd5 && major_r == CW'(x2_r) - CW'(1));
    out_data.pixel_x = px;
    out_data.pixel_y = py;
    out_data.pixel_color = {8'hff, scl(color_r[23:16], cov), scl(color_r[15:8], cov),
                            scl(color_r[7:0], cov)};
    out_data.visible = (32'(px) < 32'(TILE_SIZE_DEF)) && (32'(py) < 32'(TILE_SIZE_DEF)) &&
                       (px < clip_width) && (py < clip_height);
    out_data.last = sts.final_pixel;
  end
endmodule

// File: hw/rtl/antialiased_line_rasterizer.sv
// Xiaolin Wu antialiased line rasterizer for one tile. A line transaction
// is accepted, its slope is found by the bit-serial divider, and then
// pixels go out at one per cycle while out_ready is high (4 endpoint
// pixels plus 2 per interior column, up to 64).
// The next line is taken after the last pixel is accepted. Clip registers
// at 0x0 (width) and 0x4 (height) are 6 bits, reset 32.
module antialiased_line_rasterizer #(
  parameter int FRAC_BITS = alr_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  alr_pkg::line_in_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output alr_pkg::pixel_out_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import alr_pkg::*;

  logic [5:0] clip_w_r, clip_h_r;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_w_r <= 6'd32;
      clip_h_r <= 6'd32;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == REG_CLIP_WIDTH) begin
        clip_w_r <= cfg_pwdata[5:0];
      end else begin
        clip_h_r <= cfg_pwdata[5:0];
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'b00) begin
      cfg_prdata = (cfg_paddr[2] == REG_CLIP_HEIGHT) ? 32'(clip_h_r) : 32'(clip_w_r);
    end
  end

  alr_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
  );

  alr_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .in_data, .cmd, .sts,
    .clip_width(clip_w_r), .clip_height(clip_h_r), .out_data
  );
endmodule
